[hw/rtl/sdrd_pkg.sv]
// ----------------------------------------------------------------------------
// sdrd_pkg
// Shared types, constants and the crc16 byte update for the sd spi block read
// sequencer.
// ----------------------------------------------------------------------------
package sdrd_pkg;

  localparam int unsigned RespLimitW  = 8;
  localparam int unsigned TokenLimitW = 24;
  localparam int unsigned AttemptW    = 4;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned CfgIndexW   = 2;

  localparam logic [RespLimitW-1:0]  RespLimitRst  = 8'd255;
  localparam logic [TokenLimitW-1:0] TokenLimitRst = 24'd16711425;
  localparam logic [AttemptW-1:0]    AttemptsRst   = 4'd4;

  localparam logic [7:0]  CmdBase    = 8'h40;
  localparam logic [7:0]  CmdCrc     = 8'h95;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [7:0]  TokenStart = 8'hFE;
  localparam logic [7:0]  IdleByte   = 8'hFF;
  localparam logic [7:0]  CmdSetLen  = 8'd16;
  localparam logic [2:0]  FrameLast  = 3'd5;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_RESP_LIMIT  = 2'd0,
    CFG_TOKEN_LIMIT = 2'd1,
    CFG_MAX_ATTEMPT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_READY      = 4'd1,
    PH_FRAME      = 4'd2,
    PH_RESP       = 4'd3,
    PH_TOKEN      = 4'd4,
    PH_DATA       = 4'd5,
    PH_CRC_HI     = 4'd6,
    PH_CRC_LO     = 4'd7,
    PH_RETRY_TRL  = 4'd8,
    PH_OK_TRL     = 4'd9,
    PH_FAIL_TRL   = 4'd10
  } phase_e;

  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                chip_select;
    logic                data_valid;
    logic [7:0]          data_byte;
    logic [AttemptW-1:0] attempt_number;
    logic                done_res;
    logic                success;
  } res_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] crc;
    logic        top;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      top = crc[15] ^ b[7-i];
      crc = {crc[14:0], 1'b0};
      if (top) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

[hw/rtl/sdrd_seq.sv]
// ----------------------------------------------------------------------------
// sdrd_seq
// Command, poll, data and crc sequencer. Updates its state on every accepted
// word and forms the matching result word.
// ----------------------------------------------------------------------------
module sdrd_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdrd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [sdrd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          accept_i,
  input  logic                          command_i,
  input  logic [31:0]                   block_address_i,
  input  logic [7:0]                    block_length_i,
  input  logic                          verify_crc_i,
  input  logic [7:0]                    rx_byte_i,
  output sdrd_pkg::res_t                res_o
);
  import sdrd_pkg::*;

  logic [RespLimitW-1:0]  resp_limit_q;
  logic [TokenLimitW-1:0] token_limit_q;
  logic [AttemptW-1:0]    max_attempts_q;

  phase_e                 phase_q, phase_d;
  logic [2:0]             frame_cnt_q, frame_cnt_d;
  logic                   is_read_q, is_read_d;
  logic [RespLimitW-1:0]  resp_cnt_q, resp_cnt_d;
  logic [TokenLimitW-1:0] token_cnt_q, token_cnt_d;
  logic [7:0]             data_cnt_q, data_cnt_d;
  logic [15:0]            run_crc_q, run_crc_d;
  logic [15:0]            rx_crc_q, rx_crc_d;
  logic [AttemptW-1:0]    attempt_q, attempt_d;
  logic [31:0]            addr_q, addr_d;
  logic [7:0]             len_q, len_d;
  logic                   verify_q, verify_d;

  logic [31:0]            frame_arg;
  logic [2:0]             frame_nxt;
  logic [7:0]             frame_tx;
  logic [RespLimitW-1:0]  resp_inc;
  logic [TokenLimitW-1:0] token_inc;
  logic [7:0]             data_inc;
  logic [15:0]            rx_crc_full;
  logic [AttemptW:0]      attempt_inc;
  logic                   have_resp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_limit_q   <= RespLimitRst;
      token_limit_q  <= TokenLimitRst;
      max_attempts_q <= AttemptsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RESP_LIMIT:  resp_limit_q   <= cfg_data_i[RespLimitW-1:0];
        CFG_TOKEN_LIMIT: token_limit_q  <= cfg_data_i[TokenLimitW-1:0];
        CFG_MAX_ATTEMPT: max_attempts_q <= cfg_data_i[AttemptW-1:0];
        default: ;
      endcase
    end
  end

  // command frame byte following the current one
  assign frame_arg   = is_read_q ? addr_q : {24'd0, len_q};
  assign frame_nxt   = frame_cnt_q + 3'd1;
  always_comb begin
    case (frame_nxt)
      3'd1:    frame_tx = frame_arg[31:24];
      3'd2:    frame_tx = frame_arg[23:16];
      3'd3:    frame_tx = frame_arg[15:8];
      3'd4:    frame_tx = frame_arg[7:0];
      3'd5:    frame_tx = CmdCrc;
      default: frame_tx = IdleByte;
    endcase
  end

  assign resp_inc    = resp_cnt_q + RespLimitW'(1);
  assign token_inc   = token_cnt_q + TokenLimitW'(1);
  assign data_inc    = data_cnt_q + 8'd1;
  assign rx_crc_full = {rx_crc_q[15:8], rx_byte_i};
  assign attempt_inc = {1'b0, attempt_q} + (AttemptW+1)'(1);
  assign have_resp   = (rx_byte_i != IdleByte) || (resp_inc == resp_limit_q);

  always_comb begin
    phase_d     = phase_q;
    frame_cnt_d = frame_cnt_q;
    is_read_d   = is_read_q;
    resp_cnt_d  = resp_cnt_q;
    token_cnt_d = token_cnt_q;
    data_cnt_d  = data_cnt_q;
    run_crc_d   = run_crc_q;
    rx_crc_d    = rx_crc_q;
    attempt_d   = attempt_q;
    addr_d      = addr_q;
    len_d       = len_q;
    verify_d    = verify_q;
    res_o       = '0;

    if (!command_i) begin
      addr_d      = block_address_i;
      len_d       = block_length_i;
      verify_d    = verify_crc_i;
      attempt_d   = '0;
      is_read_d   = 1'b0;
      frame_cnt_d = '0;
      if (block_length_i == 8'd0) begin
        phase_d        = PH_IDLE;
        res_o.done_res = 1'b1;
        res_o.success  = 1'b1;
      end else begin
        phase_d           = PH_READY;
        res_o.tx_valid    = 1'b1;
        res_o.tx_byte     = IdleByte;
        res_o.chip_select = 1'b1;
      end
    end else begin
      res_o.tx_valid    = 1'b1;
      res_o.tx_byte     = IdleByte;
      res_o.chip_select = 1'b1;
      unique case (phase_q)
        PH_READY: begin
          if (rx_byte_i == IdleByte) begin
            frame_cnt_d   = '0;
            phase_d       = PH_FRAME;
            res_o.tx_byte = CmdBase | (CmdSetLen + {7'd0, is_read_q});
          end
        end
        PH_FRAME: begin
          if (frame_cnt_q >= FrameLast) begin
            resp_cnt_d = '0;
            phase_d    = PH_RESP;
          end else begin
            frame_cnt_d   = frame_nxt;
            res_o.tx_byte = frame_tx;
          end
        end
        PH_RESP: begin
          if (rx_byte_i == IdleByte) begin
            resp_cnt_d = resp_inc;
          end
          if (have_resp) begin
            if (rx_byte_i != 8'd0) begin
              phase_d           = PH_FAIL_TRL;
              res_o.chip_select = 1'b0;
            end else if (!is_read_q) begin
              is_read_d = 1'b1;
              phase_d   = PH_READY;
            end else begin
              token_cnt_d = '0;
              phase_d     = PH_TOKEN;
            end
          end
        end
        PH_TOKEN: begin
          if (rx_byte_i == TokenStart) begin
            data_cnt_d = '0;
            run_crc_d  = '0;
            phase_d    = PH_DATA;
          end else if (rx_byte_i != IdleByte) begin
            phase_d           = PH_FAIL_TRL;
            res_o.chip_select = 1'b0;
          end else begin
            token_cnt_d = token_inc;
            if (token_inc == token_limit_q) begin
              phase_d           = PH_FAIL_TRL;
              res_o.chip_select = 1'b0;
            end
          end
        end
        PH_DATA: begin
          res_o.data_valid     = 1'b1;
          res_o.data_byte      = rx_byte_i;
          res_o.attempt_number = attempt_q;
          run_crc_d            = crc16_byte(run_crc_q, rx_byte_i);
          data_cnt_d           = data_inc;
          if (data_inc == len_q) begin
            phase_d = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          rx_crc_d = {rx_byte_i, rx_crc_q[7:0]};
          phase_d  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc_d          = rx_crc_full;
          res_o.chip_select = 1'b0;
          if (verify_q && (rx_crc_full != run_crc_q)) begin
            phase_d = (attempt_inc >= {1'b0, max_attempts_q}) ? PH_FAIL_TRL : PH_RETRY_TRL;
          end else begin
            phase_d = PH_OK_TRL;
          end
        end
        PH_RETRY_TRL: begin
          attempt_d   = attempt_inc[AttemptW-1:0];
          is_read_d   = 1'b0;
          frame_cnt_d = '0;
          phase_d     = PH_READY;
        end
        PH_OK_TRL: begin
          phase_d = PH_IDLE;
          res_o   = '0;
          res_o.done_res = 1'b1;
          res_o.success  = 1'b1;
        end
        PH_FAIL_TRL: begin
          phase_d = PH_IDLE;
          res_o   = '0;
          res_o.done_res = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
          res_o   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      frame_cnt_q <= '0;
      is_read_q   <= 1'b0;
      resp_cnt_q  <= '0;
      token_cnt_q <= '0;
      data_cnt_q  <= '0;
      run_crc_q   <= '0;
      rx_crc_q    <= '0;
      attempt_q   <= '0;
      addr_q      <= '0;
      len_q       <= '0;
      verify_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      frame_cnt_q <= frame_cnt_d;
      is_read_q   <= is_read_d;
      resp_cnt_q  <= resp_cnt_d;
      token_cnt_q <= token_cnt_d;
      data_cnt_q  <= data_cnt_d;
      run_crc_q   <= run_crc_d;
      rx_crc_q    <= rx_crc_d;
      attempt_q   <= attempt_d;
      addr_q      <= addr_d;
      len_q       <= len_d;
      verify_q    <= verify_d;
    end
  end

endmodule

[hw/rtl/sdrd_out_reg.sv]
// ----------------------------------------------------------------------------
// sdrd_out_reg
// Result register between the sequencer and the output channel. Takes a new
// word whenever it is empty or its word is taken in the same cycle.
// ----------------------------------------------------------------------------
module sdrd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sdrd_pkg::res_t res_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output sdrd_pkg::res_t res_o
);
  import sdrd_pkg::*;

  logic valid_q;
  res_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[hw/rtl/sd_spi_block_read_crc_retry.sv]
// ----------------------------------------------------------------------------
// sd_spi_block_read_crc_retry
// SD card spi mode single block read sequencer with crc16 check and retry.
//
// Input channel: a start word (command 0) latches address, length and verify
// flag; every later word (command 1) carries the byte the card returned for
// the byte last sent. Each input word yields exactly one result word: the
// next byte to send with its chip select, a received data byte with its
// attempt number, or the end of the transaction with its status.
// The result word is registered and appears in the cycle after the input
// word is taken. One word per cycle while the receiver is ready; state and
// result word are formed in one pass; the result register is the only stage.
// When the receiver stalls, the result register holds its word and the input
// ready follows the output ready, so nothing is lost or repeated.
// Reset clears the sequencer to idle and loads the poll limits (255 and
// 16711425) and the attempt limit (4). The configuration port writes a
// limit and is meant to be used while the block is idle.
// ----------------------------------------------------------------------------
module sd_spi_block_read_crc_retry (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdrd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [sdrd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [31:0]                    block_address_i,
  input  logic [7:0]                     block_length_i,
  input  logic                           verify_crc_i,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           tx_valid_o,
  output logic [7:0]                     tx_byte_o,
  output logic                           chip_select_o,
  output logic                           data_valid_o,
  output logic [7:0]                     data_byte_o,
  output logic [sdrd_pkg::AttemptW-1:0]  attempt_number_o,
  output logic                           done_res_o,
  output logic                           success_o
);
  import sdrd_pkg::*;

  logic accept;
  logic space;
  res_t res_d;
  res_t res_q;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  sdrd_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .command_i       (command_i),
    .block_address_i (block_address_i),
    .block_length_i  (block_length_i),
    .verify_crc_i    (verify_crc_i),
    .rx_byte_i       (rx_byte_i),
    .res_o           (res_d)
  );

  sdrd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_d),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_q)
  );

  assign tx_valid_o       = res_q.tx_valid;
  assign tx_byte_o        = res_q.tx_byte;
  assign chip_select_o    = res_q.chip_select;
  assign data_valid_o     = res_q.data_valid;
  assign data_byte_o      = res_q.data_byte;
  assign attempt_number_o = res_q.attempt_number;
  assign done_res_o       = res_q.done_res;
  assign success_o        = res_q.success;

endmodule

[dv/sd_spi_block_read_crc_retry_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sd_spi_block_read_crc_retry_tb
// Drives start words and card reply bytes into the sd spi block read
// sequencer. A behavioural card picks each reply from the sequencer phase, and
// an in-bench copy of the sequencer predicts every result word. Results are
// checked in order, field by field, under random stalls on both channels.
// ----------------------------------------------------------------------------
module sd_spi_block_read_crc_retry_tb;
  import sdrd_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned RandomWords   = 200;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [7:0]  length;
    logic        verify;
    logic [7:0]  rx;
  } host_word_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic                 command_i       = 1'b0;
  logic [31:0]          block_address_i = '0;
  logic [7:0]           block_length_i  = '0;
  logic                 verify_crc_i    = 1'b0;
  logic [7:0]           rx_byte_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic                 tx_valid_o;
  logic [7:0]           tx_byte_o;
  logic                 chip_select_o;
  logic                 data_valid_o;
  logic [7:0]           data_byte_o;
  logic [AttemptW-1:0]  attempt_number_o;
  logic                 done_res_o;
  logic                 success_o;

  // sequencer copy
  phase_e                 seq_phase;
  logic [2:0]             frame_idx;
  logic                   reading;
  logic [7:0]             r1_polls;
  logic [TokenLimitW-1:0] token_polls;
  logic [7:0]             bytes_seen;
  logic [15:0]            crc_acc;
  logic [15:0]            crc_rx;
  logic [AttemptW-1:0]    attempt;
  logic [31:0]            blk_addr;
  logic [7:0]             blk_len;
  logic                   blk_verify;
  logic [RespLimitW-1:0]  r1_limit;
  logic [TokenLimitW-1:0] token_limit;
  logic [AttemptW-1:0]    attempt_limit;

  res_t        predicted_replies[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned card_words  = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  bit          sink_hold_req = 1'b0;

  // card behaviour, in percent per byte
  int unsigned busy_pct, r1_ok_pct, r1_bad_pct, tok_ok_pct, tok_bad_pct, crc_bad_pct;

  sd_spi_block_read_crc_retry DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .block_address_i (block_address_i),
    .block_length_i  (block_length_i),
    .verify_crc_i    (verify_crc_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .chip_select_o   (chip_select_o),
    .data_valid_o    (data_valid_o),
    .data_byte_o     (data_byte_o),
    .attempt_number_o(attempt_number_o),
    .done_res_o      (done_res_o),
    .success_o       (success_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sd_spi_block_read_crc_retry: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] crc_ccitt_update(logic [15:0] c, logic [7:0] d);
    logic [15:0] acc;
    acc = c ^ {d, 8'h00};
    repeat (8) acc = acc[15] ? ((acc << 1) ^ CrcPoly) : (acc << 1);
    return acc;
  endfunction

  function automatic logic [7:0] cmd_frame_byte(logic [2:0] idx);
    logic [31:0] arg;
    arg = reading ? blk_addr : {24'h0, blk_len};
    case (idx)
      3'd0:    return CmdBase | (CmdSetLen + 8'(reading));
      3'd1:    return arg[31:24];
      3'd2:    return arg[23:16];
      3'd3:    return arg[15:8];
      3'd4:    return arg[7:0];
      3'd5:    return CmdCrc;
      default: return IdleByte;
    endcase
  endfunction

  function automatic res_t spi_out(logic [7:0] b, logic cs);
    res_t r;
    r = '0;
    r.tx_valid    = 1'b1;
    r.tx_byte     = b;
    r.chip_select = cs;
    return r;
  endfunction

  function automatic void advance_sequencer(input host_word_t w, output res_t r);
    logic hit;
    r = '0;
    if (!w.command) begin
      blk_addr   = w.address;
      blk_len    = w.length;
      blk_verify = w.verify;
      attempt    = '0;
      reading    = 1'b0;
      frame_idx  = '0;
      if (w.length == 8'd0) begin
        seq_phase  = PH_IDLE;
        r.done_res = 1'b1;
        r.success  = 1'b1;
      end else begin
        seq_phase = PH_READY;
        r = spi_out(IdleByte, 1'b1);
      end
    end else begin
      case (seq_phase)
        PH_READY: begin
          if (w.rx == IdleByte) begin
            frame_idx = '0;
            seq_phase = PH_FRAME;
            r = spi_out(cmd_frame_byte(3'd0), 1'b1);
          end else begin
            r = spi_out(IdleByte, 1'b1);
          end
        end
        PH_FRAME: begin
          if (frame_idx >= FrameLast) begin
            r1_polls  = '0;
            seq_phase = PH_RESP;
            r = spi_out(IdleByte, 1'b1);
          end else begin
            frame_idx = frame_idx + 3'd1;
            r = spi_out(cmd_frame_byte(frame_idx), 1'b1);
          end
        end
        PH_RESP: begin
          hit = 1'b0;
          if (w.rx != IdleByte) begin
            hit = 1'b1;
          end else begin
            r1_polls = r1_polls + 8'd1;
            if (r1_polls == r1_limit) hit = 1'b1;
          end
          if (!hit) begin
            r = spi_out(IdleByte, 1'b1);
          end else if (w.rx != 8'h00) begin
            seq_phase = PH_FAIL_TRL;
            r = spi_out(IdleByte, 1'b0);
          end else if (!reading) begin
            reading   = 1'b1;
            seq_phase = PH_READY;
            r = spi_out(IdleByte, 1'b1);
          end else begin
            token_polls = '0;
            seq_phase   = PH_TOKEN;
            r = spi_out(IdleByte, 1'b1);
          end
        end
        PH_TOKEN: begin
          if (w.rx == TokenStart) begin
            bytes_seen = '0;
            crc_acc    = '0;
            seq_phase  = PH_DATA;
            r = spi_out(IdleByte, 1'b1);
          end else if (w.rx != IdleByte) begin
            seq_phase = PH_FAIL_TRL;
            r = spi_out(IdleByte, 1'b0);
          end else begin
            token_polls = token_polls + 24'd1;
            if (token_polls == token_limit) begin
              seq_phase = PH_FAIL_TRL;
              r = spi_out(IdleByte, 1'b0);
            end else begin
              r = spi_out(IdleByte, 1'b1);
            end
          end
        end
        PH_DATA: begin
          r = spi_out(IdleByte, 1'b1);
          r.data_valid     = 1'b1;
          r.data_byte      = w.rx;
          r.attempt_number = attempt;
          crc_acc    = crc_ccitt_update(crc_acc, w.rx);
          bytes_seen = bytes_seen + 8'd1;
          if (bytes_seen == blk_len) seq_phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc_rx[15:8] = w.rx;
          seq_phase    = PH_CRC_LO;
          r = spi_out(IdleByte, 1'b1);
        end
        PH_CRC_LO: begin
          crc_rx[7:0] = w.rx;
          if (blk_verify && crc_rx != crc_acc) begin
            seq_phase = (int'(attempt) + 1 >= int'(attempt_limit)) ? PH_FAIL_TRL : PH_RETRY_TRL;
          end else begin
            seq_phase = PH_OK_TRL;
          end
          r = spi_out(IdleByte, 1'b0);
        end
        PH_RETRY_TRL: begin
          attempt   = attempt + 4'd1;
          reading   = 1'b0;
          frame_idx = '0;
          seq_phase = PH_READY;
          r = spi_out(IdleByte, 1'b1);
        end
        PH_OK_TRL: begin
          seq_phase  = PH_IDLE;
          r.done_res = 1'b1;
          r.success  = 1'b1;
        end
        PH_FAIL_TRL: begin
          seq_phase  = PH_IDLE;
          r.done_res = 1'b1;
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
  endfunction

  function automatic int unsigned idle_stretch();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // card reply to the byte last sent, steered by the sequencer phase
  function automatic logic [7:0] card_reply();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (seq_phase)
      PH_READY: return (roll < busy_pct) ? 8'($urandom_range(0, 254)) : IdleByte;
      PH_RESP: begin
        if (roll < r1_ok_pct) return 8'h00;
        if (roll < r1_ok_pct + r1_bad_pct) return 8'($urandom_range(1, 254));
        return IdleByte;
      end
      PH_TOKEN: begin
        if (roll < tok_ok_pct) return TokenStart;
        if (roll < tok_ok_pct + tok_bad_pct) return 8'($urandom_range(0, 253));
        return IdleByte;
      end
      PH_CRC_HI: return (roll < crc_bad_pct) ? 8'($urandom) : crc_acc[15:8];
      PH_CRC_LO: return (roll < crc_bad_pct) ? 8'($urandom) : crc_acc[7:0];
      default:   return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 8'd0;
    if (roll < 7) return 8'($urandom_range(9, 255));
    return 8'($urandom_range(1, 8));
  endfunction

  task automatic card_behaviour(input int unsigned busy, input int unsigned r1_ok,
                                input int unsigned r1_bad, input int unsigned tok_ok,
                                input int unsigned tok_bad, input int unsigned crc_bad);
    busy_pct    = busy;
    r1_ok_pct   = r1_ok;
    r1_bad_pct  = r1_bad;
    tok_ok_pct  = tok_ok;
    tok_bad_pct = tok_bad;
    crc_bad_pct = crc_bad;
  endtask

  task automatic send_word(input host_word_t w);
    res_t        want;
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? idle_stretch() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    command_i       <= w.command;
    block_address_i <= w.address;
    block_length_i  <= w.length;
    verify_crc_i    <= w.verify;
    rx_byte_i       <= w.rx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!w.command || seq_phase != PH_IDLE) card_words++;
    advance_sequencer(w, want);
    predicted_replies.push_back(want);
  endtask

  task automatic send_start(input logic [31:0] addr, input logic [7:0] len, input logic verify);
    send_word('{command: 1'b0, address: addr, length: len, verify: verify, rx: 8'($urandom)});
  endtask

  task automatic send_reply(input logic [7:0] rx);
    send_word('{command: 1'b1, address: $urandom, length: 8'($urandom),
                verify: 1'($urandom), rx: rx});
  endtask

  // one read from start to done; abort_pm is the per-mille chance of a restart per word
  task automatic run_read(input logic [31:0] addr, input logic [7:0] len, input logic verify,
                          input int unsigned abort_pm);
    send_start(addr, len, verify);
    while (seq_phase != PH_IDLE) begin
      if (abort_pm != 0 && $urandom_range(0, 999) < abort_pm) begin
        send_start($urandom, rand_len(), 1'($urandom_range(0, 1)));
      end else begin
        send_reply(card_reply());
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RESP_LIMIT:  r1_limit      = value[RespLimitW-1:0];
      CFG_TOKEN_LIMIT: token_limit   = value[TokenLimitW-1:0];
      CFG_MAX_ATTEMPT: attempt_limit = value[AttemptW-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {tx_valid_o, tx_byte_o, chip_select_o, data_valid_o, data_byte_o,
             attempt_number_o, done_res_o, success_o};
      if (predicted_replies.size() == 0) begin
        $display("%0t: result word with nothing expected, got %h", $time, got);
        fail_count++;
      end else begin
        want = predicted_replies.pop_front();
        compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
        compare_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
        compare_field("data_byte", want.data_byte, got.data_byte);
        compare_field("attempt_number", 8'(want.attempt_number), 8'(got.attempt_number));
        compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
        compare_field("success", 8'(want.success), 8'(got.success));
      end
    end
  end

  // result receiver with random stalls and the long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = idle_stretch() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic test_basic_reads();
    card_behaviour(0, 100, 0, 100, 0, 0);
    send_reply(8'h00);
    send_reply(8'hFF);
    send_reply(8'h5A);
    send_start(32'hFFFF_FFFF, 8'd0, 1'b1);
    send_start(32'h0000_0000, 8'd0, 1'b0);
    run_read(32'h0000_0000, 8'd1, 1'b1, 0);
    run_read(32'hFFFF_FFFF, 8'd255, 1'b1, 0);
    card_behaviour(30, 40, 0, 30, 0, 100);
    run_read(32'hA5A5_5A5A, 8'd3, 1'b0, 0);
    send_reply(8'hFF);
  endtask

  task automatic test_start_while_busy();
    card_behaviour(20, 50, 0, 40, 0, 20);
    repeat (3) run_read($urandom, 8'($urandom_range(1, 6)), 1'b1, 60);
    // zero length start abandons a running read
    send_start($urandom, 8'd4, 1'b1);
    repeat (9) send_reply(card_reply());
    send_start($urandom, 8'd0, 1'b1);
  endtask

  task automatic test_r1_response();
    write_cfg(CFG_RESP_LIMIT, {16'($urandom), 8'd1});
    card_behaviour(10, 50, 0, 60, 0, 10);
    repeat (2) run_read($urandom, rand_len(), 1'b1, 0);
    card_behaviour(10, 0, 100, 60, 0, 10);
    run_read($urandom, 8'($urandom_range(1, 8)), 1'b1, 0);
    write_cfg(CFG_RESP_LIMIT, 24'd255);
    card_behaviour(10, 50, 50, 60, 0, 10);
    repeat (2) run_read($urandom, 8'($urandom_range(1, 8)), 1'b1, 0);
    // silent card: zero limit polls 256 bytes
    card_behaviour(0, 0, 0, 60, 0, 10);
    write_cfg(CFG_RESP_LIMIT, 24'd0);
    run_read($urandom, 8'd2, 1'b1, 0);
    write_cfg(CFG_RESP_LIMIT, 24'($urandom_range(2, 12)));
    card_behaviour(10, 15, 3, 60, 0, 10);
    repeat (2) run_read($urandom, rand_len(), 1'b1, 0);
  endtask

  task automatic test_token_poll();
    write_cfg(CFG_RESP_LIMIT, 24'd255);
    write_cfg(CFG_TOKEN_LIMIT, 24'd1);
    card_behaviour(10, 60, 0, 50, 0, 10);
    repeat (2) run_read($urandom, rand_len(), 1'b1, 0);
    card_behaviour(10, 60, 0, 0, 100, 10);
    run_read($urandom, 8'($urandom_range(1, 8)), 1'b1, 0);
    write_cfg(CFG_TOKEN_LIMIT, 24'd0);
    card_behaviour(10, 60, 0, 10, 0, 10);
    run_read($urandom, 8'($urandom_range(1, 8)), 1'b1, 0);
    write_cfg(CFG_TOKEN_LIMIT, TokenLimitRst);
    run_read($urandom, 8'($urandom_range(1, 8)), 1'b1, 0);
    write_cfg(CFG_TOKEN_LIMIT, 24'($urandom_range(2, 20)));
    card_behaviour(10, 60, 0, 8, 2, 10);
    repeat (2) run_read($urandom, rand_len(), 1'b1, 0);
  endtask

  task automatic test_crc_retry();
    write_cfg(CFG_TOKEN_LIMIT, 24'd64);
    card_behaviour(5, 70, 0, 50, 0, 100);
    write_cfg(CFG_MAX_ATTEMPT, {20'($urandom), 4'd0});
    run_read($urandom, 8'($urandom_range(1, 4)), 1'b1, 0);
    write_cfg(CFG_MAX_ATTEMPT, 24'd1);
    run_read($urandom, 8'($urandom_range(1, 4)), 1'b1, 0);
    write_cfg(CFG_MAX_ATTEMPT, 24'd15);
    run_read($urandom, 8'd1, 1'b1, 0);
    write_cfg(CFG_UNUSED, 24'($urandom));
    write_cfg(CFG_MAX_ATTEMPT, 24'd4);
    card_behaviour(5, 70, 0, 50, 0, 40);
    repeat (2) run_read($urandom, rand_len(), 1'($urandom_range(0, 1)), 0);
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    card_behaviour(0, 100, 0, 100, 0, 0);
    sink_hold_req = 1'b1;
    run_read($urandom, 8'd40, 1'b1, 0);
    wait_idle();
    run_read($urandom, 8'd8, 1'b1, 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random();
    int unsigned reads;
    int unsigned sel;
    logic [23:0] v;
    reads      = 0;
    card_words = 0;
    while (card_words < RandomWords) begin
      if (reads % 8 == 0) begin
        sel = $urandom_range(0, 3);
        case (sel)
          0:       v = 24'd1;
          1:       v = 24'd255;
          2:       v = 24'd0;
          default: v = 24'($urandom_range(2, 254));
        endcase
        write_cfg(CFG_RESP_LIMIT, {16'($urandom), v[7:0]});
        sel = $urandom_range(0, 5);
        case (sel)
          0:       v = 24'd1;
          1:       v = 24'd0;
          2:       v = TokenLimitRst;
          3:       v = 24'($urandom);
          default: v = 24'($urandom_range(2, 40));
        endcase
        write_cfg(CFG_TOKEN_LIMIT, v);
        write_cfg(CFG_MAX_ATTEMPT, {20'($urandom), 4'($urandom_range(0, 15))});
        card_behaviour($urandom_range(0, 30), $urandom_range(10, 90), $urandom_range(0, 5),
                       $urandom_range(10, 80), $urandom_range(0, 5), $urandom_range(0, 50));
      end
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) send_reply(8'($urandom));
      run_read($urandom, rand_len(), 1'($urandom_range(0, 4) != 0), 5);
      reads++;
    end
  endtask

  initial begin
    seq_phase     = PH_IDLE;
    frame_idx     = '0;
    reading       = 1'b0;
    r1_polls      = '0;
    token_polls   = '0;
    bytes_seen    = '0;
    crc_acc       = '0;
    crc_rx        = '0;
    attempt       = '0;
    blk_addr      = '0;
    blk_len       = '0;
    blk_verify    = 1'b0;
    r1_limit      = RespLimitRst;
    token_limit   = TokenLimitRst;
    attempt_limit = AttemptsRst;
    card_behaviour(0, 100, 0, 100, 0, 0);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_reads();
    test_start_while_busy();
    test_r1_response();
    test_token_poll();
    test_crc_retry();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sd_spi_block_read_crc_retry: match");
    end else begin
      $display("sd_spi_block_read_crc_retry: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sdrd_pkg.sv
hw/rtl/sdrd_seq.sv
hw/rtl/sdrd_out_reg.sv
hw/rtl/sd_spi_block_read_crc_retry.sv
dv/sd_spi_block_read_crc_retry_tb.sv
